// File: rtl/core/assert_macros.svh
// Assertion helpers used by the port-level checker ash_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ash_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ash_pkg
// Shared types and codes of the alignment statistics histogrammer.
// ---------------------------------------------------------------------------
package ash_pkg;

  // word function codes
  localparam logic [1:0] FN_RECORD = 2'd0;
  localparam logic [1:0] FN_FINAL  = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // table selector codes
  localparam logic [2:0] TS_COUNTERS = 3'd0;
  localparam logic [2:0] TS_LENGTH   = 3'd1;
  localparam logic [2:0] TS_ALLREF   = 3'd2;
  localparam logic [2:0] TS_PRIMREF  = 3'd3;
  localparam logic [2:0] TS_EDIT     = 3'd4;
  localparam logic [2:0] TS_REPL     = 3'd5;

  // scalar counter numbers
  localparam int unsigned NUM_COUNTERS = 10;
  localparam logic [3:0] C_ALN     = 4'd0;
  localparam logic [3:0] C_PRIM    = 4'd1;
  localparam logic [3:0] C_MAPPED  = 4'd2;
  localparam logic [3:0] C_PMAPPED = 4'd3;
  localparam logic [3:0] C_DUP     = 4'd4;
  localparam logic [3:0] C_FWD     = 4'd5;
  localparam logic [3:0] C_REV     = 4'd6;
  localparam logic [3:0] C_SAME    = 4'd7;
  localparam logic [3:0] C_BASES   = 4'd8;
  localparam logic [3:0] C_EDIT    = 4'd9;

  // result queue depth
  localparam int unsigned OUT_DEPTH = 3;

  // one access to a histogram bank
  typedef struct packed {
    logic req;   // access this cycle
    logic bump;  // 1: increment the bin, 0: read it out
  } hist_op_t;

endpackage

// File: rtl/core/ash_hist_bank.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ash_hist_bank
// One histogram memory with read-modify-write and write-to-read forwarding.
// ---------------------------------------------------------------------------
module ash_hist_bank import ash_pkg::*; #(
  parameter int unsigned BINS  = 256,
  parameter int unsigned W     = 48,
  parameter int unsigned CLR_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hist_op_t         op_i,
  input  logic [31:0]      key_i,
  input  logic             clr_i,
  input  logic [CLR_W-1:0] clr_addr_i,
  output logic [W-1:0]     value_o
);

  localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;

  logic [W-1:0]  mem_q [BINS];
  logic [W-1:0]  rdata_q;
  logic [AW-1:0] addr_s0;
  logic          s1_valid_q, s1_bump_q;
  logic [AW-1:0] s1_addr_q;
  logic          wq_valid_q;
  logic [AW-1:0] wq_addr_q;
  logic [W-1:0]  wq_data_q;
  logic [W-1:0]  cur;
  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;

  // saturate keys beyond the table into the last bin
  assign addr_s0 = (key_i < 32'(BINS)) ? key_i[AW-1:0] : AW'(BINS - 1);

  // the word just ahead wrote this bin at the edge we read it
  assign cur     = (wq_valid_q && (wq_addr_q == s1_addr_q)) ? wq_data_q : rdata_q;
  assign value_o = cur;

  always_comb begin
    if (clr_i) begin
      we    = (32'(clr_addr_i) < 32'(BINS));
      waddr = clr_addr_i[AW-1:0];
      wdata = '0;
    end else begin
      we    = s1_valid_q && s1_bump_q;
      waddr = s1_addr_q;
      wdata = cur + W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[addr_s0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_bump_q  <= 1'b0;
      wq_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= op_i.req;
      s1_bump_q  <= op_i.bump;
      wq_valid_q <= !clr_i && s1_valid_q && s1_bump_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr_s0;
    wq_addr_q <= s1_addr_q;
    wq_data_q <= wdata;
  end

endmodule

// File: rtl/core/ash_out_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ash_out_fifo
// Small result queue between the pipeline and the output channel.
// ---------------------------------------------------------------------------
module ash_out_fifo import ash_pkg::*; #(
  parameter int unsigned W = 65
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic [1:0]   count_o
);

  logic [W-1:0] buf_q [OUT_DEPTH];
  logic [1:0]   wr_q, rd_q, cnt_q;

  function automatic logic [1:0] nxt(input logic [1:0] p);
    return (p == 2'(OUT_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = buf_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/core/alignment_stats_histogrammer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alignment_stats_histogrammer
// Alignment record statistics: scalar counters and five histograms.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis; tuser carries the function (record,
//   finalize, read) and the table selector. Records and finalize words
//   update state and return nothing; a read word returns one word on
//   m_axis with the counter or bin value and an out-of-range flag.
//   Throughput is one word per cycle while s_axis_tready is high: each
//   histogram is a memory with one read and one write port and a registered
//   read; the bin is incremented in the following cycle, and back-to-back
//   hits on one bin are forwarded from the write register.
//   A read word is registered in the second stage and then written into the
//   result queue, which raises m_axis_tvalid; its result is taken when the
//   output is free.
//   After reset the block sweeps all histogram memories to zero, one bin a
//   cycle, for the largest bin count (1024 bins at the defaults); tready
//   stays low during the sweep.
//   When the receiver stalls, results queue in a three-word buffer and
//   s_axis_tready drops only once queued plus in-flight reads fill it.
// ---------------------------------------------------------------------------
module alignment_stats_histogrammer import ash_pkg::*; #(
  parameter int unsigned LEN_BINS    = 1024,
  parameter int unsigned REF_BINS    = 256,
  parameter int unsigned EDIT_BINS   = 256,
  parameter int unsigned REPL_BINS   = 1024,
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // read_length[15:0] is_mapped[16] is_primary[17] is_duplicate[18]
  // is_reverse[19] ref_id[35:20] position[66:36] has_edit_tag[67]
  // edit_dist[83:68] bin_index[93:84], zero pad [95:94]
  input  logic [95:0] s_axis_tdata,
  // func[1:0] table_sel[4:2]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[63:0]
  output logic [63:0] m_axis_tdata,
  // out_of_range[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int unsigned MAX_A   = (LEN_BINS > REF_BINS) ? LEN_BINS : REF_BINS;
  localparam int unsigned MAX_B   = (EDIT_BINS > REPL_BINS) ? EDIT_BINS : REPL_BINS;
  localparam int unsigned MAX_BINS = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int unsigned CLR_W   = $clog2(MAX_BINS + 1);

  // field decode
  logic [1:0]  func;
  logic [2:0]  tsel;
  logic [15:0] rlen, ref_id, edit_dist;
  logic [30:0] pos;
  logic [9:0]  bin;
  logic        mapped, primary, dup, rev, has_tag;

  assign func      = s_axis_tuser[1:0];
  assign tsel      = s_axis_tuser[4:2];
  assign rlen      = s_axis_tdata[15:0];
  assign mapped    = s_axis_tdata[16];
  assign primary   = s_axis_tdata[17];
  assign dup       = s_axis_tdata[18];
  assign rev       = s_axis_tdata[19];
  assign ref_id    = s_axis_tdata[35:20];
  assign pos       = s_axis_tdata[66:36];
  assign has_tag   = s_axis_tdata[67];
  assign edit_dist = s_axis_tdata[83:68];
  assign bin       = s_axis_tdata[93:84];

  // clearing sweep after reset
  logic [CLR_W-1:0] clr_cnt_q;
  logic             clr_busy;
  assign clr_busy = (clr_cnt_q < CLR_W'(MAX_BINS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + CLR_W'(1);
    end
  end

  // accept control: queued results plus reads in flight stay within the queue
  logic       s1_rd_q;
  logic [1:0] fifo_cnt;
  logic       fire, is_rec, is_fin, is_rd;

  assign s_axis_tready = !clr_busy &&
                         (({1'b0, fifo_cnt} + {2'b0, s1_rd_q}) < 3'(OUT_DEPTH));
  assign fire   = s_axis_tvalid && s_axis_tready;
  assign is_rec = fire && (func == FN_RECORD);
  assign is_fin = fire && (func == FN_FINAL);
  assign is_rd  = fire && (func == FN_READ);

  // previous-record tracking
  logic        prev_valid_q, prev_mapped_q;
  logic [15:0] prev_ref_q;
  logic [30:0] prev_pos_q;
  logic [31:0] run_q;
  logic        cmp, same_pos, repl_bump;

  assign cmp       = mapped && prev_valid_q && prev_mapped_q;
  assign same_pos  = (ref_id == prev_ref_q) && (pos == prev_pos_q);
  assign repl_bump = (is_rec && cmp && !same_pos) || (is_fin && (run_q != 32'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q  <= 1'b0;
      prev_mapped_q <= 1'b0;
      prev_ref_q    <= '0;
      prev_pos_q    <= '0;
      run_q         <= '0;
    end else if (is_rec) begin
      prev_valid_q  <= 1'b1;
      prev_mapped_q <= mapped;
      prev_ref_q    <= ref_id;
      prev_pos_q    <= pos;
      if (cmp) begin
        // extend a run on a repeated start, otherwise close it
        if (same_pos) begin
          if (run_q != '1) run_q <= run_q + 32'd1;
        end else begin
          run_q <= '0;
        end
      end
    end else if (is_fin) begin
      prev_valid_q  <= 1'b0;
      prev_mapped_q <= 1'b0;
      prev_ref_q    <= '0;
      prev_pos_q    <= '0;
      run_q         <= '0;
    end
  end

  // scalar counters
  logic [63:0] cnt_q [NUM_COUNTERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
    end else if (is_rec) begin
      cnt_q[C_ALN] <= cnt_q[C_ALN] + 64'd1;
      if (primary) cnt_q[C_PRIM] <= cnt_q[C_PRIM] + 64'd1;
      if (dup)     cnt_q[C_DUP]  <= cnt_q[C_DUP] + 64'd1;
      if (mapped) begin
        cnt_q[C_MAPPED] <= cnt_q[C_MAPPED] + 64'd1;
        if (primary) begin
          cnt_q[C_PMAPPED] <= cnt_q[C_PMAPPED] + 64'd1;
          if (has_tag) begin
            cnt_q[C_BASES] <= cnt_q[C_BASES] + 64'(rlen);
            cnt_q[C_EDIT]  <= cnt_q[C_EDIT] + 64'(edit_dist);
          end
        end
        if (rev) cnt_q[C_REV] <= cnt_q[C_REV] + 64'd1;
        else     cnt_q[C_FWD] <= cnt_q[C_FWD] + 64'd1;
      end
      if (cmp && same_pos) cnt_q[C_SAME] <= cnt_q[C_SAME] + 64'd1;
    end
  end

  // histogram bank requests
  hist_op_t    len_op, all_op, prim_op, edit_op, repl_op;
  logic [31:0] bin_key;

  assign bin_key = 32'(bin);

  always_comb begin
    len_op.req   = is_rec || (is_rd && (tsel == TS_LENGTH));
    len_op.bump  = is_rec;
    all_op.req   = (is_rec && mapped) || (is_rd && (tsel == TS_ALLREF));
    all_op.bump  = is_rec;
    prim_op.req  = (is_rec && mapped && primary) || (is_rd && (tsel == TS_PRIMREF));
    prim_op.bump = is_rec;
    edit_op.req  = (is_rec && mapped && primary && has_tag) ||
                   (is_rd && (tsel == TS_EDIT));
    edit_op.bump = is_rec;
    repl_op.req  = repl_bump || (is_rd && (tsel == TS_REPL));
    repl_op.bump = repl_bump;
  end

  logic [COUNT_WIDTH-1:0] len_v, all_v, prim_v, edit_v, repl_v;

  ash_hist_bank #(.BINS(LEN_BINS), .W(COUNT_WIDTH), .CLR_W(CLR_W)) u_len (
    .clk_i, .rst_ni, .op_i(len_op), .key_i(is_rec ? 32'(rlen) : bin_key),
    .clr_i(clr_busy), .clr_addr_i(clr_cnt_q), .value_o(len_v));

  ash_hist_bank #(.BINS(REF_BINS), .W(COUNT_WIDTH), .CLR_W(CLR_W)) u_allref (
    .clk_i, .rst_ni, .op_i(all_op), .key_i(is_rec ? 32'(ref_id) : bin_key),
    .clr_i(clr_busy), .clr_addr_i(clr_cnt_q), .value_o(all_v));

  ash_hist_bank #(.BINS(REF_BINS), .W(COUNT_WIDTH), .CLR_W(CLR_W)) u_primref (
    .clk_i, .rst_ni, .op_i(prim_op), .key_i(is_rec ? 32'(ref_id) : bin_key),
    .clr_i(clr_busy), .clr_addr_i(clr_cnt_q), .value_o(prim_v));

  ash_hist_bank #(.BINS(EDIT_BINS), .W(COUNT_WIDTH), .CLR_W(CLR_W)) u_edit (
    .clk_i, .rst_ni, .op_i(edit_op), .key_i(is_rec ? 32'(edit_dist) : bin_key),
    .clr_i(clr_busy), .clr_addr_i(clr_cnt_q), .value_o(edit_v));

  ash_hist_bank #(.BINS(REPL_BINS), .W(COUNT_WIDTH), .CLR_W(CLR_W)) u_repl (
    .clk_i, .rst_ni, .op_i(repl_op), .key_i(repl_bump ? run_q : bin_key),
    .clr_i(clr_busy), .clr_addr_i(clr_cnt_q), .value_o(repl_v));

  // read decode in the accept cycle
  logic        oor_s0;
  logic [63:0] cval_s0;

  always_comb begin
    case (tsel)
      TS_COUNTERS: oor_s0 = (32'(bin) >= NUM_COUNTERS);
      TS_LENGTH:   oor_s0 = (bin_key >= 32'(LEN_BINS));
      TS_ALLREF:   oor_s0 = (bin_key >= 32'(REF_BINS));
      TS_PRIMREF:  oor_s0 = (bin_key >= 32'(REF_BINS));
      TS_EDIT:     oor_s0 = (bin_key >= 32'(EDIT_BINS));
      TS_REPL:     oor_s0 = (bin_key >= 32'(REPL_BINS));
      default:     oor_s0 = 1'b1;
    endcase
    cval_s0 = (32'(bin) < NUM_COUNTERS) ? cnt_q[bin[3:0]] : 64'd0;
  end

  // second stage: pick the value and queue the result
  logic [2:0]  s1_sel_q;
  logic        s1_oor_q;
  logic [63:0] s1_cval_q;
  logic [63:0] rd_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_rd_q <= 1'b0;
    end else begin
      s1_rd_q <= is_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q  <= tsel;
    s1_oor_q  <= oor_s0;
    s1_cval_q <= cval_s0;
  end

  always_comb begin
    case (s1_sel_q)
      TS_COUNTERS: rd_val = s1_cval_q;
      TS_LENGTH:   rd_val = 64'(len_v);
      TS_ALLREF:   rd_val = 64'(all_v);
      TS_PRIMREF:  rd_val = 64'(prim_v);
      TS_EDIT:     rd_val = 64'(edit_v);
      TS_REPL:     rd_val = 64'(repl_v);
      default:     rd_val = 64'd0;
    endcase
    if (s1_oor_q) rd_val = 64'd0;
  end

  logic [64:0] fifo_out;

  ash_out_fifo #(.W(65)) u_out (
    .clk_i, .rst_ni,
    .push_i (s1_rd_q),
    .data_i ({s1_oor_q, rd_val}),
    .pop_i  (m_axis_tvalid && m_axis_tready),
    .valid_o(m_axis_tvalid),
    .data_o (fifo_out),
    .count_o(fifo_cnt));

  assign m_axis_tdata = fifo_out[63:0];
  assign m_axis_tuser = fifo_out[64];

endmodule

// File: rtl/core/ash_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ash_checker
// Port-level checks of the alignment statistics histogrammer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ash_checker import ash_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [4:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic rd_fire;
  assign rd_fire = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == FN_READ);

  `ASH_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")
  `ASH_ASSERT_NOW(a_oor_zero, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata == 64'd0, "out-of-range word carries data")
  `ASH_ASSERT_NOW(a_result_src, $rose(m_axis_tvalid), $past(rd_fire, 2),
    "result without a read word")

endmodule

bind alignment_stats_histogrammer ash_checker u_ash_checker (.*);

// File: bench/alignment_stats_histogrammer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alignment_stats_histogrammer_checker
// Watches both streams, keeps its own copy of the statistics, predicts the
// reply of every read word and compares it with the word that comes back.
// ---------------------------------------------------------------------------
module alignment_stats_histogrammer_checker import ash_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [4:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int LEN_N = 1024, REF_N = 256, EDIT_N = 256, REPL_N = 1024;

  typedef struct packed {
    logic [63:0] value;
    logic        oor;
  } reply_t;

  logic [63:0] stat_cnt [NUM_COUNTERS];
  logic [47:0] len_h [LEN_N];
  logic [47:0] aref_h [REF_N];
  logic [47:0] pref_h [REF_N];
  logic [47:0] edit_h [EDIT_N];
  logic [47:0] repl_h [REPL_N];
  logic [31:0] dup_run;
  logic        last_ok, last_mapped;
  logic [15:0] last_ref;
  logic [30:0] last_pos;
  reply_t      replies_due [$];

  assign pending_o = replies_due.size();

  function automatic int clip(longint unsigned v, int n);
    return (v < n) ? int'(v) : n - 1;
  endfunction

  task automatic absorb_word(input logic [95:0] d, input logic [4:0] u);
    logic [15:0] len, rid, edv;
    logic        mp, pr, dp, rv, tag;
    logic [30:0] pos;
    logic [9:0]  idx;
    int          k;
    reply_t      r;
    len = d[15:0]; mp = d[16]; pr = d[17]; dp = d[18]; rv = d[19];
    rid = d[35:20]; pos = d[66:36]; tag = d[67]; edv = d[83:68];
    idx = d[93:84];
    case (u[1:0])
      FN_RECORD: begin
        stat_cnt[C_ALN]++;
        k = clip(len, LEN_N); len_h[k]++;
        if (pr) stat_cnt[C_PRIM]++;
        if (dp) stat_cnt[C_DUP]++;
        if (mp) begin
          stat_cnt[C_MAPPED]++;
          k = clip(rid, REF_N); aref_h[k]++;
          if (pr) begin
            stat_cnt[C_PMAPPED]++;
            pref_h[k]++;
            if (tag) begin
              stat_cnt[C_BASES] += 64'(len);
              stat_cnt[C_EDIT] += 64'(edv);
              k = clip(edv, EDIT_N); edit_h[k]++;
            end
          end
          if (rv) stat_cnt[C_REV]++;
          else stat_cnt[C_FWD]++;
        end
        if (last_ok && mp && last_mapped) begin
          if (rid == last_ref && pos == last_pos) begin
            if (dup_run != 32'hFFFF_FFFF) dup_run++;
            stat_cnt[C_SAME]++;
          end else begin
            k = clip(dup_run, REPL_N); repl_h[k]++;
            dup_run = 0;
          end
        end
        last_ok = 1; last_mapped = mp; last_ref = rid; last_pos = pos;
      end
      FN_FINAL: begin
        if (dup_run != 0) begin
          k = clip(dup_run, REPL_N); repl_h[k]++;
        end
        dup_run = 0; last_ok = 0; last_mapped = 0; last_ref = 0; last_pos = 0;
      end
      FN_READ: begin
        r = '{value: 64'd0, oor: 1'b1};
        case (u[4:2])
          TS_COUNTERS: if (idx < NUM_COUNTERS) r = '{stat_cnt[idx], 1'b0};
          TS_LENGTH:   if (idx < LEN_N)  r = '{{16'd0, len_h[idx]}, 1'b0};
          TS_ALLREF:   if (idx < REF_N)  r = '{{16'd0, aref_h[idx]}, 1'b0};
          TS_PRIMREF:  if (idx < REF_N)  r = '{{16'd0, pref_h[idx]}, 1'b0};
          TS_EDIT:     if (idx < EDIT_N) r = '{{16'd0, edit_h[idx]}, 1'b0};
          TS_REPL:     if (idx < REPL_N) r = '{{16'd0, repl_h[idx]}, 1'b0};
          default: ;
        endcase
        replies_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  initial begin
    fail_count_o = 0;
    foreach (stat_cnt[i]) stat_cnt[i] = 0;
    foreach (len_h[i]) len_h[i] = 0;
    foreach (aref_h[i]) aref_h[i] = 0;
    foreach (pref_h[i]) pref_h[i] = 0;
    foreach (edit_h[i]) edit_h[i] = 0;
    foreach (repl_h[i]) repl_h[i] = 0;
    dup_run = 0; last_ok = 0; last_mapped = 0; last_ref = 0; last_pos = 0;
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          note_mismatch("unexpected word", 64'd0, m_axis_tdata);
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata !== want.value)
            note_mismatch("read_data", want.value, m_axis_tdata);
          if (m_axis_tuser[0] !== want.oor)
            note_mismatch("out_of_range", 64'(want.oor), 64'(m_axis_tuser));
        end
      end
      if (s_axis_tvalid && s_axis_tready) absorb_word(s_axis_tdata, s_axis_tuser);
    end
  end
endmodule

// File: bench/alignment_stats_histogrammer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alignment_stats_histogrammer_test
// Drives records, finalize and read words through the histogrammer under
// several idle/stall phases; the checker predicts and compares read replies.
// ---------------------------------------------------------------------------
module alignment_stats_histogrammer_test import ash_pkg::*;;
  localparam int WATCHDOG = 20000;
  // codes the block ignores or reports as out of range
  localparam logic [1:0] FN_UNUSED  = 2'd3;
  localparam logic [2:0] TS_SPARE_A = 3'd6;
  localparam logic [2:0] TS_SPARE_B = 3'd7;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0, reads_sent = 0;

  // small pools of references and positions so duplicate runs happen
  logic [15:0] ref_pool [4] = '{16'd0, 16'd3, 16'd255, 16'd300};
  logic [30:0] pos_pool [4] = '{31'd0, 31'd17, 31'd1000, 31'h7FFF_FFFF};

  always #5 clk_i = ~clk_i;

  alignment_stats_histogrammer uut (.*);

  alignment_stats_histogrammer_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .fail_count_o(fail_count), .pending_o(pending));

  // receiver: stall at the phase's rate
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [95:0] pack_word(
      logic [15:0] len, logic mp, logic pr, logic dp, logic rv,
      logic [15:0] rid, logic [30:0] pos, logic tag, logic [15:0] edv,
      logic [9:0] idx);
    return {2'b00, idx, edv, tag, pos, rid, rv, dp, pr, mp, len};
  endfunction

  // hold one word until it is taken; idle before it at the phase's rate
  task automatic send(input logic [1:0] fn, input logic [2:0] sel,
                      input logic [95:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {sel, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (fn == FN_READ) reads_sent++;
  endtask

  task automatic read_bin(input logic [2:0] sel, input logic [9:0] idx);
    send(FN_READ, sel, pack_word(16'($urandom), 1'($urandom), 1'($urandom),
         1'($urandom), 1'($urandom), 16'($urandom), 31'($urandom),
         1'($urandom), 16'($urandom), idx));
  endtask

  task automatic send_record(input logic [15:0] len, input logic mp,
                             input logic pr, input logic [15:0] rid,
                             input logic [30:0] pos, input logic [15:0] edv);
    send(FN_RECORD, 3'($urandom), pack_word(len, mp, pr, 1'($urandom),
         1'($urandom), rid, pos, 1'($urandom), edv, 10'($urandom)));
  endtask

  task automatic random_word();
    int     pick;
    logic [2:0] sel;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_record(16'($urandom_range(3) == 0 ? $urandom : $urandom_range(1100)),
        $urandom_range(4) != 0, 1'($urandom),
        $urandom_range(5) == 0 ? 16'($urandom) : ref_pool[$urandom_range(3)],
        $urandom_range(5) == 0 ? 31'($urandom) : pos_pool[$urandom_range(3)],
        16'($urandom_range(3) == 0 ? $urandom : $urandom_range(300)));
    end else if (pick < 66) begin
      send(FN_FINAL, 3'($urandom), {$urandom, $urandom, $urandom});
    end else if (pick < 68) begin
      send(FN_UNUSED, 3'($urandom), {$urandom, $urandom, $urandom});
    end else begin
      sel = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? TS_SPARE_A
                                                                 : TS_SPARE_B)
                                     : 3'($urandom_range(5));
      read_bin(sel, 10'($urandom_range(3) == 0 ? $urandom : (sel == TS_COUNTERS
        ? $urandom_range(9) : $urandom_range(8))));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every function, each special case
    send_record(16'hFFFF, 1, 1, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF);
    send_record(16'd0, 1, 1, 16'hFFFF, 31'h7FFF_FFFF, 16'd0);
    send_record(16'd5, 1, 0, 16'hFFFF, 31'h7FFF_FFFF, 16'd3);
    send_record(16'd7, 0, 1, 16'd0, 31'd0, 16'd1);
    send_record(16'd7, 1, 1, 16'd0, 31'd0, 16'd1);
    send_record(16'd7, 1, 1, 16'd0, 31'd1, 16'd1);
    send_record(16'd7, 1, 1, 16'd0, 31'd1, 16'd1);
    send(FN_FINAL, TS_COUNTERS, '0);
    send(FN_FINAL, TS_COUNTERS, '0);
    send(FN_UNUSED, TS_SPARE_B, '1);
    for (int c = 0; c < NUM_COUNTERS; c++) read_bin(TS_COUNTERS, 10'(c));
    read_bin(TS_COUNTERS, 10'd10);
    read_bin(TS_LENGTH, 10'd1023);
    read_bin(TS_ALLREF, 10'd255);
    read_bin(TS_PRIMREF, 10'd256);
    read_bin(TS_EDIT, 10'd255);
    read_bin(TS_REPL, 10'd1);
    read_bin(TS_SPARE_A, 10'd0);
    read_bin(TS_SPARE_B, 10'h3FF);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 12 : 0;
      recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 12 : 0;
      for (int n = 0; n < 150; n++) random_word();
      if (ph == 1) begin
        // hold off until every reply has drained
        s_axis_tvalid <= 0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end
    // read the low and the top bins of every table and all counters
    recv_stall_pct = 0; send_idle_pct = 0;
    for (int b = 0; b < 32; b++) begin
      read_bin(TS_LENGTH, 10'(b)); read_bin(TS_REPL, 10'(b));
      read_bin(TS_ALLREF, 10'(b)); read_bin(TS_PRIMREF, 10'(b));
      read_bin(TS_EDIT, 10'(b));
    end
    for (int b = 0; b < 8; b++) begin
      read_bin(TS_LENGTH, 10'(1016 + b)); read_bin(TS_REPL, 10'(1016 + b));
      read_bin(TS_ALLREF, 10'(248 + b)); read_bin(TS_PRIMREF, 10'(248 + b));
      read_bin(TS_EDIT, 10'(248 + b));
    end
    for (int c = 0; c < NUM_COUNTERS; c++) read_bin(TS_COUNTERS, 10'(c));
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d words, %0d of them reads, over four idle/stall phases",
             words_sent, reads_sent);
    $display("then read back the low and top bins of each table and all counters");
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
